// ===== rtl/hcd_pkg.sv =====
// shared types and constants for the chunked body decoder
// no dependencies; used by http_chunked_decoder_core and its checker
package hcd_pkg;

  // width of the chunk size register
  localparam int SIZE_BITS = 32;
  // wide enough for size + 5 and for the 32 bit saturated count
  localparam int NEED_BITS = ((SIZE_BITS > 32) ? SIZE_BITS : 32) + 1;

  // sizes above this limit leave no room for the closing framing bytes
  localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = {SIZE_BITS{1'b1}} - SIZE_BITS'(5);

  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [3:0] {
    ST_START    = 4'd0,
    ST_SIZE     = 4'd1,
    ST_EXT      = 4'd2,
    ST_EXT_CR   = 4'd3,
    ST_DATA     = 4'd4,
    ST_AFTER    = 4'd5,
    ST_AFTER_CR = 4'd6,
    ST_LEXT     = 4'd7,
    ST_LEXT_CR  = 4'd8,
    ST_TRL      = 4'd9,
    ST_TRL_CR   = 4'd10,
    ST_THDR     = 4'd11,
    ST_THDR_CR  = 4'd12,
    ST_ERR      = 4'd13
  } parse_state_e;

  typedef enum logic [1:0] {
    K_FRAME = 2'd0,
    K_DATA  = 2'd1,
    K_DONE  = 2'd2,
    K_ERR   = 2'd3
  } beat_kind_e;

endpackage

// ===== rtl/http_chunked_decoder_core.sv =====
// chunked transfer body decoder: classifies each body byte, counts payload
// depends on hcd_pkg
// pipeline: an accepted beat enters the input register, then the result register, where it is taken
// throughput: one byte per cycle unless the receiver stalls; parser state and chunk size update as each byte moves on
// reset: asynchronous, clears both stages' valids, parser to chunk start, size to 0
// error state is sticky until reset
module http_chunked_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        chunk_last_o,
  output logic [31:0] needed_bytes_o
);

  localparam int SB = hcd_pkg::SIZE_BITS;
  localparam int NB = hcd_pkg::NEED_BITS;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // result register
  logic        out_vld_q;
  hcd_pkg::beat_kind_e kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [31:0] need_q, need_d;

  // parser state
  hcd_pkg::parse_state_e st_q, st_d;
  logic [SB-1:0] rem_q, rem_d;

  logic adv_res;   // input register moves into the result register
  logic adv_in;    // a new beat enters the input register

  // the result register frees up when empty or when its beat is taken
  assign adv_res    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv_res;
  assign adv_in     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv_in || adv_res) begin
      in_vld_q <= adv_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in) begin
      in_byte_q <= in_byte_i;
    end
  end

  // hex digit decode, either case
  logic       hex_ok;
  logic [3:0] hex_v;
  logic [7:0] low_ch;

  always_comb begin
    low_ch = in_byte_q | hcd_pkg::CASE_BIT;
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (in_byte_q inside {["0":"9"]}) begin
      hex_v = in_byte_q[3:0];
    end else if (low_ch inside {["a":"f"]}) begin
      hex_v = 4'(low_ch - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  logic is_cr, is_lf, is_ext;
  assign is_cr  = (in_byte_q == hcd_pkg::CH_CR);
  assign is_lf  = (in_byte_q == hcd_pkg::CH_LF);
  assign is_ext = (in_byte_q == hcd_pkg::CH_SEMI) || (in_byte_q == hcd_pkg::CH_SP) ||
                  (in_byte_q == hcd_pkg::CH_TAB);

  logic err, done, rem_nz;
  hcd_pkg::beat_kind_e kind;
  logic [7:0]  pay;
  logic        last;
  logic [NB-1:0] need_w;
  hcd_pkg::parse_state_e st_n;

  assign rem_nz = (rem_q != '0);

  // next state and result of one byte
  always_comb begin
    st_n  = st_q;
    rem_d = rem_q;
    err   = 1'b0;
    done  = 1'b0;
    kind  = hcd_pkg::K_FRAME;
    pay   = 8'd0;
    last  = 1'b0;
    case (st_q)
      hcd_pkg::ST_START: begin
        if (hex_ok) begin
          rem_d = SB'(hex_v);
          st_n  = hcd_pkg::ST_SIZE;
        end else begin
          err = 1'b1;
        end
      end
      hcd_pkg::ST_SIZE: begin
        // with the top digit in use any byte is an error: one more digit would overflow the size register
        if (rem_q[SB-1 -: 4] != 4'd0) begin
          err = 1'b1;
        end else if (hex_ok) begin
          rem_d = {rem_q[SB-5:0], hex_v};
        end else if (is_cr) begin
          st_n = rem_nz ? hcd_pkg::ST_EXT_CR : hcd_pkg::ST_LEXT_CR;
        end else if (is_lf) begin
          st_n = rem_nz ? hcd_pkg::ST_DATA : hcd_pkg::ST_TRL;
        end else if (is_ext) begin
          st_n = rem_nz ? hcd_pkg::ST_EXT : hcd_pkg::ST_LEXT;
        end else begin
          err = 1'b1;
        end
      end
      hcd_pkg::ST_EXT: begin
        if (is_cr) st_n = hcd_pkg::ST_EXT_CR;
        else if (is_lf) st_n = hcd_pkg::ST_DATA;
      end
      hcd_pkg::ST_EXT_CR: begin
        if (is_lf) st_n = hcd_pkg::ST_DATA;
        else err = 1'b1;
      end
      hcd_pkg::ST_DATA: begin
        kind = hcd_pkg::K_DATA;
        pay  = in_byte_q;
        if (rem_nz) rem_d = rem_q - SB'(1);
        if (rem_d == '0) begin
          last = 1'b1;
          st_n = hcd_pkg::ST_AFTER;
        end
      end
      hcd_pkg::ST_AFTER: begin
        if (is_cr) st_n = hcd_pkg::ST_AFTER_CR;
        else if (is_lf) st_n = hcd_pkg::ST_START;
      end
      hcd_pkg::ST_AFTER_CR: begin
        if (is_lf) st_n = hcd_pkg::ST_START;
        else err = 1'b1;
      end
      hcd_pkg::ST_LEXT: begin
        if (is_cr) st_n = hcd_pkg::ST_LEXT_CR;
        else if (is_lf) st_n = hcd_pkg::ST_TRL;
      end
      hcd_pkg::ST_LEXT_CR: begin
        if (is_lf) st_n = hcd_pkg::ST_TRL;
        else err = 1'b1;
      end
      hcd_pkg::ST_TRL: begin
        if (is_cr) st_n = hcd_pkg::ST_TRL_CR;
        else if (is_lf) done = 1'b1;
        else st_n = hcd_pkg::ST_THDR;
      end
      hcd_pkg::ST_TRL_CR: begin
        if (is_lf) done = 1'b1;
        else err = 1'b1;
      end
      hcd_pkg::ST_THDR: begin
        if (is_cr) st_n = hcd_pkg::ST_THDR_CR;
        else if (is_lf) st_n = hcd_pkg::ST_TRL;
      end
      hcd_pkg::ST_THDR_CR: begin
        if (is_lf) st_n = hcd_pkg::ST_TRL;
        else err = 1'b1;
      end
      default: begin
        // sticky error, and the unused codes
        err = 1'b1;
      end
    endcase

    // no room left for the closing framing
    if (!err && !done && (rem_d > hcd_pkg::SIZE_LIMIT)) begin
      err = 1'b1;
    end

    // lower bound on bytes still to come, from the state after this byte
    case (st_n)
      hcd_pkg::ST_START:    need_w = NB'(3);
      hcd_pkg::ST_SIZE:     need_w = (rem_d != '0) ? (NB'(rem_d) + NB'(5)) : NB'(2);
      hcd_pkg::ST_EXT,
      hcd_pkg::ST_EXT_CR:   need_w = NB'(rem_d) + NB'(5);
      hcd_pkg::ST_DATA:     need_w = NB'(rem_d) + NB'(4);
      hcd_pkg::ST_AFTER,
      hcd_pkg::ST_AFTER_CR: need_w = NB'(4);
      hcd_pkg::ST_LEXT,
      hcd_pkg::ST_LEXT_CR:  need_w = NB'(2);
      hcd_pkg::ST_TRL,
      hcd_pkg::ST_TRL_CR:   need_w = NB'(1);
      hcd_pkg::ST_THDR,
      hcd_pkg::ST_THDR_CR:  need_w = NB'(2);
      default:              need_w = '0;
    endcase

    st_d   = st_n;
    kind_d = kind;
    byte_d = pay;
    last_d = last;
    need_d = (need_w[NB-1:32] != '0) ? 32'hffff_ffff : need_w[31:0];
    if (err) begin
      st_d   = hcd_pkg::ST_ERR;
      kind_d = hcd_pkg::K_ERR;
      byte_d = 8'd0;
      last_d = 1'b0;
      need_d = 32'd0;
    end else if (done) begin
      // ready for the next message
      st_d   = hcd_pkg::ST_START;
      rem_d  = '0;
      kind_d = hcd_pkg::K_DONE;
      byte_d = 8'd0;
      last_d = 1'b0;
      need_d = 32'd0;
    end
  end

  // parser state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= hcd_pkg::ST_START;
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_res) begin
        st_q  <= st_d;
        rem_q <= rem_d;
      end
      if (adv_res || !out_stall_i) begin
        out_vld_q <= adv_res;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (adv_res) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      last_q <= last_d;
      need_q <= need_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_kind_o     = kind_q;
  assign out_byte_o     = byte_q;
  assign chunk_last_o   = last_q;
  assign needed_bytes_o = need_q;

endmodule

// ===== rtl/hcd_checker.sv =====
// port level checks for http_chunked_decoder_core, bound into http_chunked_decoder_core
// depends on hcd_pkg
module hcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  out_kind_o,
  input logic [7:0]  out_byte_o,
  input logic        chunk_last_o,
  input logic [31:0] needed_bytes_o
);

  logic out_acc;
  logic err_seen_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // set once an error beat has left the block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (out_acc && (out_kind_o == hcd_pkg::K_ERR)) begin
      err_seen_q <= 1'b1;
    end
  end

  // error is sticky: every later beat is an error
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_seen_q && out_valid_o) |-> (out_kind_o == hcd_pkg::K_ERR))
    else $error("beat after an error is not an error");

  // only payload beats carry a byte or the chunk end flag
  a_payload_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o != hcd_pkg::K_DATA)) |-> (out_byte_o == 8'd0 && !chunk_last_o))
    else $error("framing beat carries payload");

  // completion and error expect nothing more
  a_need_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o == hcd_pkg::K_DONE || out_kind_o == hcd_pkg::K_ERR))
      |-> (needed_bytes_o == 32'd0))
    else $error("nonzero byte count at end of message");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_kind_o) && $stable(out_byte_o) &&
       $stable(chunk_last_o) && $stable(needed_bytes_o)))
    else $error("stalled result beat changed");

endmodule

bind http_chunked_decoder_core hcd_checker u_hcd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_kind_o     (out_kind_o),
  .out_byte_o     (out_byte_o),
  .chunk_last_o   (chunk_last_o),
  .needed_bytes_o (needed_bytes_o)
);

// ===== tb/http_chunked_decoder_core_test.sv =====
// testbench for http_chunked_decoder_core: chunked bodies are sent a byte per beat
// and each result beat is checked against a predictor kept in this file; uses hcd_pkg
module http_chunked_decoder_core_test;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT = 200000;
  // a result passes the input register and the result register before it is taken; the drain covers that tail
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 64;
  localparam int MAX_PRINTS = 40;
  localparam logic [63:0] SIZE_MAXV = (64'd1 << hcd_pkg::SIZE_BITS) - 64'd1;

  // one decoded beat as the block should report it
  typedef struct packed {
    hcd_pkg::beat_kind_e kind;
    logic [7:0]  data;
    logic        last;
    logic [31:0] need;
  } decoded_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_byte_o;
  logic        chunk_last_o;
  logic [31:0] needed_bytes_o;

  // parser copy that tracks the block
  hcd_pkg::parse_state_e dec_state = hcd_pkg::ST_START;
  logic [63:0]   dec_size = 64'd0;
  decoded_beat_t expected_beats[$];
  decoded_beat_t want_beat;

  // idle mix, in percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // long receiver hold: requests come from the tests, the stall process serves them
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int bytes_sent = 0;
  int beats_checked = 0;
  int payload_beats = 0;
  int messages_done = 0;
  int error_beats = 0;
  int mismatches = 0;

  http_chunked_decoder_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_kind_o     (out_kind_o),
    .out_byte_o     (out_byte_o),
    .chunk_last_o   (chunk_last_o),
    .needed_bytes_o (needed_bytes_o)
  );

  initial begin
    forever begin
      #CLK_HALF clk_i = ~clk_i;
    end
  end

  // watchdog on a generous cycle budget
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles with %0d beats outstanding", CYCLE_LIMIT,
             expected_beats.size());
    $display("== FAIL ==");
    $finish;
  end

  // hex digit value, -1 for anything else
  function automatic int hex_value(input logic [7:0] ch);
    logic [7:0] folded;
    folded = ch | hcd_pkg::CASE_BIT;
    if (ch >= "0" && ch <= "9") return int'(ch - "0");
    if (folded >= "a" && folded <= "f") return int'(folded - "a") + 10;
    return -1;
  endfunction

  // lower bound on the bytes still to come, saturated to 32 bits
  function automatic logic [31:0] bytes_still_needed(input hcd_pkg::parse_state_e st,
                                                     input logic [63:0] sz);
    logic [63:0] n;
    case (st)
      hcd_pkg::ST_START:                          n = 64'd3;
      hcd_pkg::ST_SIZE:                           n = (sz != 0) ? sz + 64'd5 : 64'd2;
      hcd_pkg::ST_EXT, hcd_pkg::ST_EXT_CR:        n = sz + 64'd5;
      hcd_pkg::ST_DATA:                           n = sz + 64'd4;
      hcd_pkg::ST_AFTER, hcd_pkg::ST_AFTER_CR:    n = 64'd4;
      hcd_pkg::ST_LEXT, hcd_pkg::ST_LEXT_CR:      n = 64'd2;
      hcd_pkg::ST_TRL, hcd_pkg::ST_TRL_CR:        n = 64'd1;
      hcd_pkg::ST_THDR, hcd_pkg::ST_THDR_CR:      n = 64'd2;
      default:                                    n = 64'd0;
    endcase
    return (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
  endfunction

  // advances the parser copy by one byte and gives the beat it should report
  function automatic decoded_beat_t decode_byte(input logic [7:0] ch);
    decoded_beat_t r;
    hcd_pkg::parse_state_e nxt;
    int            d;
    logic          err;
    logic          done;
    r = '{kind: hcd_pkg::K_FRAME, data: 8'h00, last: 1'b0, need: 32'd0};
    nxt = dec_state;
    err = 1'b0;
    done = 1'b0;
    d = hex_value(ch);
    case (dec_state)
      hcd_pkg::ST_START: begin
        if (d >= 0) begin
          dec_size = 64'(d);
          nxt = hcd_pkg::ST_SIZE;
        end else err = 1'b1;
      end
      hcd_pkg::ST_SIZE: begin
        // one more byte on a size this big cannot be taken
        if (dec_size > SIZE_MAXV / 64'd16) err = 1'b1;
        else if (d >= 0) dec_size = dec_size * 64'd16 + 64'(d);
        else if (ch == hcd_pkg::CH_CR)
          nxt = (dec_size != 0) ? hcd_pkg::ST_EXT_CR : hcd_pkg::ST_LEXT_CR;
        else if (ch == hcd_pkg::CH_LF)
          nxt = (dec_size != 0) ? hcd_pkg::ST_DATA : hcd_pkg::ST_TRL;
        else if (ch == hcd_pkg::CH_SEMI || ch == hcd_pkg::CH_SP || ch == hcd_pkg::CH_TAB)
          nxt = (dec_size != 0) ? hcd_pkg::ST_EXT : hcd_pkg::ST_LEXT;
        else err = 1'b1;
      end
      hcd_pkg::ST_EXT: begin
        if (ch == hcd_pkg::CH_CR) nxt = hcd_pkg::ST_EXT_CR;
        else if (ch == hcd_pkg::CH_LF) nxt = hcd_pkg::ST_DATA;
      end
      hcd_pkg::ST_EXT_CR: begin
        if (ch == hcd_pkg::CH_LF) nxt = hcd_pkg::ST_DATA;
        else err = 1'b1;
      end
      hcd_pkg::ST_DATA: begin
        r.kind = hcd_pkg::K_DATA;
        r.data = ch;
        if (dec_size != 0) dec_size = dec_size - 64'd1;
        if (dec_size == 0) begin
          r.last = 1'b1;
          nxt = hcd_pkg::ST_AFTER;
        end
      end
      hcd_pkg::ST_AFTER: begin
        if (ch == hcd_pkg::CH_CR) nxt = hcd_pkg::ST_AFTER_CR;
        else if (ch == hcd_pkg::CH_LF) nxt = hcd_pkg::ST_START;
      end
      hcd_pkg::ST_AFTER_CR: begin
        if (ch == hcd_pkg::CH_LF) nxt = hcd_pkg::ST_START;
        else err = 1'b1;
      end
      hcd_pkg::ST_LEXT: begin
        if (ch == hcd_pkg::CH_CR) nxt = hcd_pkg::ST_LEXT_CR;
        else if (ch == hcd_pkg::CH_LF) nxt = hcd_pkg::ST_TRL;
      end
      hcd_pkg::ST_LEXT_CR: begin
        if (ch == hcd_pkg::CH_LF) nxt = hcd_pkg::ST_TRL;
        else err = 1'b1;
      end
      hcd_pkg::ST_TRL: begin
        if (ch == hcd_pkg::CH_CR) nxt = hcd_pkg::ST_TRL_CR;
        else if (ch == hcd_pkg::CH_LF) done = 1'b1;
        else nxt = hcd_pkg::ST_THDR;
      end
      hcd_pkg::ST_TRL_CR: begin
        if (ch == hcd_pkg::CH_LF) done = 1'b1;
        else err = 1'b1;
      end
      hcd_pkg::ST_THDR: begin
        if (ch == hcd_pkg::CH_CR) nxt = hcd_pkg::ST_THDR_CR;
        else if (ch == hcd_pkg::CH_LF) nxt = hcd_pkg::ST_TRL;
      end
      hcd_pkg::ST_THDR_CR: begin
        if (ch == hcd_pkg::CH_LF) nxt = hcd_pkg::ST_TRL;
        else err = 1'b1;
      end
      default: err = 1'b1;
    endcase
    // no room left for the closing framing bytes
    if (!err && !done && dec_size > SIZE_MAXV - 64'd5) err = 1'b1;
    if (err) begin
      dec_state = hcd_pkg::ST_ERR;
      r = '{kind: hcd_pkg::K_ERR, data: 8'h00, last: 1'b0, need: 32'd0};
    end else if (done) begin
      dec_state = hcd_pkg::ST_START;
      dec_size = 64'd0;
      r = '{kind: hcd_pkg::K_DONE, data: 8'h00, last: 1'b0, need: 32'd0};
    end else begin
      dec_state = nxt;
      r.need = bytes_still_needed(nxt, dec_size);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch on result beat %0d: %s got 0x%0h, expected 0x%0h",
               beats_checked, field, got, want);
  endtask

  // offers one byte, entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    decoded_beat_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    r = decode_byte(b);
    expected_beats.push_back(r);
    bytes_sent++;
    case (r.kind)
      hcd_pkg::K_DATA: payload_beats++;
      hcd_pkg::K_DONE: messages_done++;
      hcd_pkg::K_ERR:  error_beats++;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // any byte except the line terminators
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == hcd_pkg::CH_CR || b == hcd_pkg::CH_LF);
    return b;
  endfunction

  // crlf or a bare lf
  task automatic send_line_end();
    if ($urandom_range(1) != 0) send_byte(hcd_pkg::CH_CR);
    send_byte(hcd_pkg::CH_LF);
  endtask

  // hex size with random case and leading zeros, optional extension, line end
  task automatic send_size_line(input logic [63:0] sz);
    int         nd;
    int         i;
    logic [3:0] nib;
    logic [7:0] ch;
    nd = 1;
    while (nd < 16 && (sz >> (4 * nd)) != 0) nd++;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) send_byte("0");
    for (i = nd - 1; i >= 0; i--) begin
      nib = sz[4*i +: 4];
      if (nib < 10) ch = 8'h30 + 8'(nib);
      else begin
        ch = 8'h61 + 8'(nib) - 8'd10;
        if ($urandom_range(1) != 0) ch = ch & ~hcd_pkg::CASE_BIT;
      end
      send_byte(ch);
    end
    if ($urandom_range(9) < 3) begin
      case ($urandom_range(2))
        0:       send_byte(hcd_pkg::CH_SEMI);
        1:       send_byte(hcd_pkg::CH_SP);
        default: send_byte(hcd_pkg::CH_TAB);
      endcase
      repeat ($urandom_range(6)) send_byte(text_byte());
    end
    send_line_end();
  endtask

  // well-formed data chunk: size line, payload, closing line end
  task automatic send_chunk(input logic [63:0] sz);
    send_size_line(sz);
    repeat (sz) send_byte(8'($urandom_range(255)));
    // junk before the line end is ignored in this state
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) send_byte(text_byte());
    send_line_end();
  endtask

  // whole message: data chunks, last chunk, trailer lines, empty line
  task automatic send_message();
    int r;
    repeat ($urandom_range(3)) begin
      r = $urandom_range(99);
      // mostly short chunks, a few long ones
      if (r < 80) send_chunk(64'($urandom_range(1, 16)));
      else if (r < 95) send_chunk(64'($urandom_range(17, 64)));
      else send_chunk(64'($urandom_range(65, 300)));
    end
    send_size_line(64'd0);
    repeat ($urandom_range(2)) begin
      send_byte(text_byte());
      repeat ($urandom_range(8)) send_byte(text_byte());
      send_line_end();
    end
    send_line_end();
  endtask

  // every framing state at least once, both line ends, all extension separators, byte extremes
  task automatic test_directed_framing();
    send_text("1 x");
    send_byte(hcd_pkg::CH_CR);
    send_text("\n");
    send_byte(8'hFF);
    send_byte(hcd_pkg::CH_CR);
    send_text("\n1\t\n");
    send_byte(8'h00);
    send_text("\n0;");
    send_byte(hcd_pkg::CH_CR);
    send_text("\nT");
    send_byte(hcd_pkg::CH_CR);
    send_text("\n");
    send_byte(hcd_pkg::CH_CR);
    send_text("\n");
  endtask

  task automatic test_random_messages(input int snd_pct, input int rcv_pct,
                                      input int n_bytes);
    int stop_at;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_message();
  endtask

  // receiver holds off while a long chunk streams in, so the block backs up
  task automatic test_backpressure_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    send_chunk(64'd48);
    send_size_line(64'd0);
    send_line_end();
  endtask

  // the error is sticky, so this runs last; the seed picks which fault trips it
  task automatic test_sticky_error();
    case ($urandom_range(6))
      0: send_text("g");
      1: send_text("1x");
      // one digit too many for the size register
      2: begin
        send_byte("1");
        repeat (hcd_pkg::SIZE_BITS / 4) send_byte("0");
      end
      // size past the limit
      3: begin
        repeat (hcd_pkg::SIZE_BITS / 4 - 1) send_byte("F");
        send_byte(8'h41 + 8'($urandom_range(1, 5)));
      end
      // largest legal size, then a cr not followed by lf
      4: begin
        repeat (hcd_pkg::SIZE_BITS / 4 - 1) send_byte("f");
        send_byte("a");
        send_byte(hcd_pkg::CH_CR);
        send_byte("Z");
      end
      5: begin
        send_text("0");
        send_byte(hcd_pkg::CH_CR);
        send_text("\nX");
        send_byte(hcd_pkg::CH_CR);
        send_byte("Y");
      end
      default: begin
        send_text("1");
        send_byte(hcd_pkg::CH_CR);
        send_text("\nQ");
        send_byte(hcd_pkg::CH_CR);
        send_byte("W");
      end
    endcase
    repeat (30) send_byte(8'($urandom_range(255)));
  endtask

  // receiver stall: random mix, or a counted hold when one is requested
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // result checker: each accepted beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) report_mismatch("unexpected beat, kind",
                                                      32'(out_kind_o), 32'd0);
      else begin
        want_beat = expected_beats.pop_front();
        if (out_kind_o !== want_beat.kind)
          report_mismatch("out_kind", 32'(out_kind_o), 32'(want_beat.kind));
        if (out_byte_o !== want_beat.data)
          report_mismatch("out_byte", 32'(out_byte_o), 32'(want_beat.data));
        if (chunk_last_o !== want_beat.last)
          report_mismatch("chunk_last", 32'(chunk_last_o), 32'(want_beat.last));
        if (needed_bytes_o !== want_beat.need)
          report_mismatch("needed_bytes", needed_bytes_o, want_beat.need);
      end
      beats_checked++;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_framing();
    test_random_messages(15, 65, 430);
    test_random_messages(65, 15, 430);
    test_random_messages(0, 0, 430);
    test_backpressure_hold();
    test_sticky_error();

    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d bytes: %0d payload beats, %0d messages completed, %0d error beats",
             bytes_sent, payload_beats, messages_done, error_beats);
    $display("idle mixes 15/65, 65/15 and none, one %0d-cycle receiver hold; %0d beats checked",
             HOLD_CYCLES, beats_checked);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
